[hw/rtl/rns_noise_flood_coeff_assert.svh]
// Assertion macros for the noise flooding block.
// Used by rns_noise_flood_coeff.sv; no other dependencies.
`ifndef RNS_NOISE_FLOOD_COEFF_ASSERT_SVH
`define RNS_NOISE_FLOOD_COEFF_ASSERT_SVH
`ifndef SYNTHESIS
// combinational condition checked at every edge out of reset
`define RNF_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("rnf assertion failed");
// condition that must hold in the cycle after the antecedent
`define RNF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rnf assertion failed");
`else
`define RNF_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define RNF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/rnf_pkg.sv]
// Shared widths, register indexes and pipeline item type for the
// noise flooding block. No dependencies.
package rnf_pkg;

   localparam int COEFF_W         = 61;
   localparam int NOISE_LOW_W     = 64;
   localparam int NOISE_HIGH_W    = 63;
   localparam int NB_W            = 7;
   localparam int SEL_W           = 2;
   localparam int NOISE_W         = 128;
   localparam int STEPS_PER_STAGE = 2;
   localparam int NUM_STAGES      = NOISE_W / STEPS_PER_STAGE;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 61;

   localparam int NUM_MODULI_DEFAULT = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_BITS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS_BASE = 3'd1;

   localparam logic [NB_W-1:0]    NOISE_BITS_RESET = 7'd40;
   localparam logic [COEFF_W-1:0] MODULUS_RESET    = 61'd2;

   // one transaction in flight through the reducer
   typedef struct packed {
      logic [COEFF_W-1:0] rem;
      logic [NOISE_W-1:0] noise;
      logic [COEFF_W-1:0] modulus;
      logic [COEFF_W-1:0] coefficient;
   } rnf_item_type;

endpackage

[hw/rtl/rnf_front.sv]
// Input stage: masks the noise word, picks the modulus, registers the item.
// Depends on rnf_pkg.
module rnf_front #(
   parameter int NUM_MODULI = rnf_pkg::NUM_MODULI_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [rnf_pkg::NOISE_LOW_W-1:0]   noise_low,
   input  logic [rnf_pkg::NOISE_HIGH_W-1:0]  noise_high,
   input  logic [rnf_pkg::COEFF_W-1:0]       coefficient,
   input  logic [rnf_pkg::SEL_W-1:0]         modulus_select,
   input  logic [rnf_pkg::NB_W-1:0]          noise_bits,
   input  logic [rnf_pkg::COEFF_W-1:0]       moduli [NUM_MODULI],
   output logic                              out_valid,
   output rnf_pkg::rnf_item_type             out_item
);

   localparam int MOD_IDX_W = (NUM_MODULI > 1) ? $clog2(NUM_MODULI) : 1;

   logic                         valid_ff, valid_in;
   rnf_pkg::rnf_item_type        item_ff, item_in;
   logic [rnf_pkg::NOISE_W-1:0]  mask;
   logic [MOD_IDX_W-1:0]         sel_idx;

   always_comb begin
      mask = (rnf_pkg::NOISE_W'(1) << noise_bits) - rnf_pkg::NOISE_W'(1);
      // selectors past the last modulus fall back to the last one
      if (int'(modulus_select) >= NUM_MODULI) begin
         sel_idx = MOD_IDX_W'(NUM_MODULI - 1);
      end else begin
         sel_idx = MOD_IDX_W'(modulus_select);
      end
      item_in.rem         = '0;
      item_in.noise       = {1'b0, noise_high, noise_low} & mask;
      item_in.modulus     = moduli[sel_idx];
      item_in.coefficient = coefficient;
      valid_in            = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

[hw/rtl/rnf_reduce_stage.sv]
// One reducer stage: STEPS_PER_STAGE restoring shift-and-subtract steps of the
// noise modulo the selected modulus. Depends on rnf_pkg.
module rnf_reduce_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  rnf_pkg::rnf_item_type  in_item,
   output logic                   out_valid,
   output rnf_pkg::rnf_item_type  out_item
);

   logic                         valid_ff;
   rnf_pkg::rnf_item_type        item_ff, item_in;
   logic [rnf_pkg::COEFF_W:0]    trial;
   logic [rnf_pkg::COEFF_W-1:0]  rem;

   always_comb begin
      rem   = in_item.rem;
      trial = '0;
      // for a nonzero modulus rem stays below it, so trial is below twice the modulus
      for (int k = 0; k < rnf_pkg::STEPS_PER_STAGE; k++) begin
         trial = {rem, in_item.noise[rnf_pkg::NOISE_W-1-k]};
         if (trial >= {1'b0, in_item.modulus}) begin
            trial = trial - {1'b0, in_item.modulus};
         end
         rem = trial[rnf_pkg::COEFF_W-1:0];
      end
      item_in             = in_item;
      item_in.rem         = rem;
      item_in.noise       = in_item.noise << rnf_pkg::STEPS_PER_STAGE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

[hw/rtl/rnf_final.sv]
// Output stage: adds the reduced noise to the coefficient, one conditional
// subtraction, result register. Depends on rnf_pkg.
module rnf_final (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  rnf_pkg::rnf_item_type         in_item,
   output logic                          out_valid,
   output logic [rnf_pkg::COEFF_W-1:0]   out_residue
);

   logic                          valid_ff;
   logic [rnf_pkg::COEFF_W-1:0]   residue_ff, residue_in;
   logic [rnf_pkg::COEFF_W-1:0]   red;
   logic [rnf_pkg::COEFF_W:0]     sum;
   logic [rnf_pkg::COEFF_W:0]     diff;

   always_comb begin
      // zero modulus: the reducer output is meaningless, noise counts as zero
      red  = (in_item.modulus == '0) ? '0 : in_item.rem;
      sum  = {1'b0, red} + {1'b0, in_item.coefficient};
      diff = sum - {1'b0, in_item.modulus};
      if (sum >= {1'b0, in_item.modulus}) begin
         residue_in = diff[rnf_pkg::COEFF_W-1:0];
      end else begin
         residue_in = sum[rnf_pkg::COEFF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         residue_ff <= residue_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_residue = residue_ff;

endmodule

[hw/rtl/rns_noise_flood_coeff.sv]
// Top level of the noise flooding block: register file, front stage,
// reducer pipeline, output stage. Depends on rnf_pkg and the assert header.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  noise_low, noise_high,
//                                            coefficient, modulus_select
//   rsp      out        rsp_valid/rsp_ready  flooded_residue
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// One transaction per cycle while the result register is not stalled; the
// reducer chain has 64 stages, two remainder bits per stage.
// Reset is synchronous: clears all valid bits, restores the registers.
// When the result register is full and not taken, every stage holds.
// csr_ready is always high; writes past the last register are dropped.
`include "rns_noise_flood_coeff_assert.svh"

module rns_noise_flood_coeff #(
   parameter int NUM_MODULI = rnf_pkg::NUM_MODULI_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [rnf_pkg::NOISE_LOW_W-1:0]    req_noise_low,
   input  logic [rnf_pkg::NOISE_HIGH_W-1:0]   req_noise_high,
   input  logic [rnf_pkg::COEFF_W-1:0]        req_coefficient,
   input  logic [rnf_pkg::SEL_W-1:0]          req_modulus_select,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [rnf_pkg::COEFF_W-1:0]        rsp_flooded_residue,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rnf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rnf_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic [rnf_pkg::NB_W-1:0]     noise_bits_ff;
   logic [rnf_pkg::COEFF_W-1:0]  moduli_ff [NUM_MODULI];
   logic                         advance;
   logic                         stage_valid [rnf_pkg::NUM_STAGES+1];
   rnf_pkg::rnf_item_type        stage_item  [rnf_pkg::NUM_STAGES+1];

   // pipeline moves as a whole unless the result register is stuck
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_bits_ff <= rnf_pkg::NOISE_BITS_RESET;
      end else if (csr_valid && csr_index == rnf_pkg::CSR_NOISE_BITS) begin
         noise_bits_ff <= csr_data[rnf_pkg::NB_W-1:0];
      end
   end

   for (genvar i = 0; i < NUM_MODULI; i++) begin : g_mod
      always_ff @(posedge clock) begin
         if (reset) begin
            moduli_ff[i] <= rnf_pkg::MODULUS_RESET;
         end else if (csr_valid &&
                      csr_index == rnf_pkg::CSR_MODULUS_BASE +
                                   rnf_pkg::CSR_IDX_W'(i)) begin
            moduli_ff[i] <= csr_data[rnf_pkg::COEFF_W-1:0];
         end
      end
   end

   rnf_front #(
      .NUM_MODULI (NUM_MODULI)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .en             (advance),
      .in_valid       (req_valid),
      .noise_low      (req_noise_low),
      .noise_high     (req_noise_high),
      .coefficient    (req_coefficient),
      .modulus_select (req_modulus_select),
      .noise_bits     (noise_bits_ff),
      .moduli         (moduli_ff),
      .out_valid      (stage_valid[0]),
      .out_item       (stage_item[0])
   );

   for (genvar s = 0; s < rnf_pkg::NUM_STAGES; s++) begin : g_stage
      rnf_reduce_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (advance),
         .in_valid  (stage_valid[s]),
         .in_item   (stage_item[s]),
         .out_valid (stage_valid[s+1]),
         .out_item  (stage_item[s+1])
      );
   end

   rnf_final u_final (
      .clock       (clock),
      .reset       (reset),
      .en          (advance),
      .in_valid    (stage_valid[rnf_pkg::NUM_STAGES]),
      .in_item     (stage_item[rnf_pkg::NUM_STAGES]),
      .out_valid   (rsp_valid),
      .out_residue (rsp_flooded_residue)
   );

   // an accepted transaction lands in the front register
   `RNF_ASSERT_NEXT(a_front_load, clock, reset, req_valid && req_ready, stage_valid[0])
   // a stalled front register keeps its transaction
   `RNF_ASSERT_NEXT(a_front_hold, clock, reset, stage_valid[0] && !advance, stage_valid[0])
   // the reducer leaves a remainder below any nonzero modulus
   `RNF_ASSERT_ALWAYS(a_rem_range, clock, reset, !stage_valid[rnf_pkg::NUM_STAGES] ||
      stage_item[rnf_pkg::NUM_STAGES].modulus == '0 ||
      stage_item[rnf_pkg::NUM_STAGES].rem < stage_item[rnf_pkg::NUM_STAGES].modulus)

endmodule
